// ----- design/grev_pkg.sv -----
package grev_pkg;

    // Fixed widths of the stream fields and the configuration register
    localparam int VALUE_W   = 32;
    localparam int GSIZE_W   = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 2;

    // Register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_GROUP_SIZE = 2'd0;

    // Group size after reset
    localparam logic [GSIZE_W-1:0] GROUP_SIZE_RST = 5'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // input transfer taken, write value to store
        logic read;     // issue the first store read of a group
        logic advance;  // output transfer taken, step to next entry
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fire;         // current input completes a group or ends the stream
        logic last_result;  // the result on show is the final one of the group
    } t_status;

endpackage

// ----- design/grev_ram.sv -----
module grev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/grev_datapath.sv -----
module grev_datapath
    import grev_pkg::*;
#(
    parameter int MAX_GROUP  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [GSIZE_W-1:0] i_group_size,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_stream_end,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_run_last,
    output logic               o_list_last
);

    localparam int AW      = $clog2(MAX_GROUP);
    localparam int CW      = $clog2(MAX_GROUP + 1);
    localparam int KW      = (CW > GSIZE_W) ? CW : GSIZE_W;
    // Only the low DATA_WIDTH bits of a value, at most VALUE_W, ever reach the output
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_left, n_left;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic               r_rev, n_rev;
    logic               r_end, n_end;

    logic [CW-1:0]      fill_c;
    logic [CW-1:0]      held;
    logic [KW-1:0]      gs;
    logic [KW-1:0]      k;
    logic               full;
    logic [AW-1:0]      ptr_step;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [STORE_W-1:0] rd_data;

    // Count of values held once this input is written
    always_comb begin
        fill_c = (r_fill >= CW'(MAX_GROUP)) ? CW'(MAX_GROUP - 1) : r_fill;
        held   = fill_c + 1'b1;
        gs     = KW'(i_group_size);
        if (gs > KW'(MAX_GROUP)) begin
            k = KW'(MAX_GROUP);
        end else if (gs == '0) begin
            k = KW'(1);
        end else begin
            k = gs;
        end
        full = (KW'(held) >= k);
    end

    assign o_status.fire        = full | i_stream_end;
    assign o_status.last_result = (r_left == CW'(1));

    // Walk the store newest first for a full group, oldest first otherwise
    assign ptr_step = r_rev ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
    assign rd_en    = i_cmd.read | i_cmd.advance;
    assign rd_addr  = i_cmd.read ? r_ptr : ptr_step;

    // Group bookkeeping
    always_comb begin
        n_fill = r_fill;
        n_left = r_left;
        n_ptr  = r_ptr;
        n_rev  = r_rev;
        n_end  = r_end;
        if (i_cmd.load) begin
            if (o_status.fire) begin
                n_fill = '0;
                n_left = held;
                n_rev  = full;
                n_ptr  = full ? fill_c[AW-1:0] : '0;
                n_end  = i_stream_end;
            end else begin
                n_fill = held;
            end
        end else if (i_cmd.advance) begin
            n_left = r_left - 1'b1;
            n_ptr  = ptr_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_left <= '0;
        end else begin
            r_fill <= n_fill;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_rev <= n_rev;
        r_end <= n_end;
    end

    grev_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_GROUP)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load),
        .i_wr_addr (fill_c[AW-1:0]),
        .i_wr_data (i_value[STORE_W-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Zero-extend stored value to the port width
    always_comb begin
        o_out_value                = '0;
        o_out_value[STORE_W-1:0]   = rd_data;
    end

    assign o_run_last  = o_status.last_result;
    assign o_list_last = o_status.last_result & r_end;

    // Held count stays below MAX_GROUP between inputs
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CW'(MAX_GROUP))
        else $error("fill count reached a full group");

    // A group that fires resets the held count and leaves results to show
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && o_status.fire) |=> (r_fill == '0) && (r_left != '0))
        else $error("fired group did not reset the fill count");

    // Stepping only happens while more results remain
    a_step_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_left > CW'(1)))
        else $error("advance past the end of a group");

endmodule

// ----- design/grev_ctrl.sv -----
module grev_ctrl
    import grev_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.fire) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SHOW;
            end
            ST_SHOW: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.last_result) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Input is taken only with no group draining
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");

    // A firing input always leads to a store read
    a_fire_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_status.fire) |=> o_cmd.read)
        else $error("group fired without a read");

    // A read is followed by a result on show
    a_read_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> o_out_valid)
        else $error("read not followed by output");

endmodule

// ----- design/stream_group_reverser.sv -----
// stream_group_reverser
// Collects a stream of values into groups of group_size and sends each
// full group out newest first. When an input carries stream_end while a
// group is only partly filled, the held values go out oldest first.
// A group_size of 0 or 1 passes values through; sizes above MAX_GROUP act
// as MAX_GROUP.
// Input channel: i_in_valid / o_in_stall with i_value, i_stream_end.
// Output channel: o_out_valid / i_out_stall with o_out_value, o_run_last
// (last result of a group) and o_list_last (last element of the stream).
// group_size is written over the APB port at address 0.
// Flow: an input that completes no group is taken in ST_IDLE. An input
// that fires a group is taken in ST_IDLE, the store is read in ST_READ,
// and ST_SHOW then gives one result per cycle while the receiver does
// not stall. The values sit in a single-port-write, registered-read
// store; the draining group blocks input until its final result
// transfer.
// While the receiver stalls, the result on show holds and nothing moves.
// Reset clears the held count and sets group_size to 1; store contents
// are not cleared and are never read before being written.
module stream_group_reverser
    import grev_pkg::*;
#(
    parameter int MAX_GROUP  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_stream_end,
    // output stream
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_run_last,
    output logic               o_list_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [GSIZE_W-1:0] r_group_size;
    logic               cfg_wr;
    t_cmd               cmd;
    t_status            status;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RST;
        end else if (cfg_wr && (paddr == ADDR_GROUP_SIZE)) begin
            r_group_size <= pwdata[GSIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_GROUP_SIZE) begin
            prdata[GSIZE_W-1:0] = r_group_size;
        end
    end

    grev_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    grev_datapath #(
        .MAX_GROUP  (MAX_GROUP),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_group_size (r_group_size),
        .i_value      (i_value),
        .i_stream_end (i_stream_end),
        .o_out_value  (o_out_value),
        .o_run_last   (o_run_last),
        .o_list_last  (o_list_last)
    );

endmodule
